### rtl/core/fan_speed_button_controller_assert.svh
// ---------------------------------------------------------------------------
// fan speed button controller assertion macros
// shared concurrent assertion forms, reset disables the check
// ---------------------------------------------------------------------------
`ifndef FAN_SPEED_BUTTON_CONTROLLER_ASSERT_SVH
`define FAN_SPEED_BUTTON_CONTROLLER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FSBC_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FSBC_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/fsbc_pkg.sv
// ---------------------------------------------------------------------------
// fsbc_pkg
// types and constants shared by the fan speed button controller
// ---------------------------------------------------------------------------
package fsbc_pkg;

    localparam int HOLD_W     = 16;
    localparam int DEB_W      = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int COUNT_W    = 16;
    localparam int SPEED_W    = 2;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 1'd1;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd2000;
    localparam logic [DEB_W-1:0]  DEB_RESET  = 8'd5;

    localparam logic [SPEED_W-1:0] SPEED_OFF  = 2'd0;
    localparam logic [SPEED_W-1:0] SPEED_LOW  = 2'd1;
    localparam logic [SPEED_W-1:0] SPEED_MID  = 2'd2;
    localparam logic [SPEED_W-1:0] SPEED_HIGH = 2'd3;

    // power in bit 0, up in bit 1, down in bit 2
    typedef struct packed {
        logic down;
        logic up;
        logic power;
    } btn_t;

    typedef struct packed {
        logic [HOLD_W-1:0] hold_ticks;
        logic [DEB_W-1:0]  debounce_ticks;
    } cfg_t;

    // relay_low in bit 0 up to speed_level in bits 5:4
    typedef struct packed {
        logic [SPEED_W-1:0] speed_level;
        logic               fan_on;
        logic               relay_high;
        logic               relay_mid;
        logic               relay_low;
    } res_t;

endpackage

### rtl/core/fsbc_cfg.sv
// ---------------------------------------------------------------------------
// fsbc_cfg
// configuration registers, hold and debounce tick counts
// ---------------------------------------------------------------------------
module fsbc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fsbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fsbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output fsbc_pkg::cfg_t                 cfg
);
    import fsbc_pkg::*;

    logic [HOLD_W-1:0] hold_reg;
    logic [DEB_W-1:0]  deb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= HOLD_RESET;
            deb_reg  <= DEB_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HOLD_TICKS:     hold_reg <= cfg_wdata[HOLD_W-1:0];
                CFG_DEBOUNCE_TICKS: deb_reg  <= cfg_wdata[DEB_W-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg.hold_ticks     = hold_reg;
    assign cfg.debounce_ticks = deb_reg;

endmodule

### rtl/core/fsbc_in_stage.sv
// ---------------------------------------------------------------------------
// fsbc_in_stage
// input register for one tick item of button levels
// ---------------------------------------------------------------------------
module fsbc_in_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fsbc_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            take,
    output logic                            item_valid,
    output fsbc_pkg::btn_t                  item
);
    import fsbc_pkg::*;

    logic valid_reg;
    logic valid_next;
    btn_t btn_reg;
    logic load;

    // free slot, or the held item moves on this cycle
    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            btn_reg <= s_tdata[2:0];
    end

    assign item_valid = valid_reg;
    assign item       = btn_reg;

endmodule

### rtl/core/fsbc_fsm.sv
// ---------------------------------------------------------------------------
// fsbc_fsm
// button sequencer, fan state and result register
// ---------------------------------------------------------------------------
module fsbc_fsm (
    input  logic           clk,
    input  logic           rst_n,
    input  fsbc_pkg::cfg_t cfg,
    input  logic           item_valid,
    input  fsbc_pkg::btn_t item,
    output logic           take,
    output logic           m_tvalid,
    input  logic           m_tready,
    output fsbc_pkg::res_t res
);
    import fsbc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_CNT_POWER = 3'd1,
        PH_CNT_UP    = 3'd2,
        PH_CNT_DOWN  = 3'd3,
        PH_REL_POWER = 3'd4,
        PH_REL_UP    = 3'd5,
        PH_REL_DOWN  = 3'd6
    } phase_t;

    phase_t             phase_reg,  phase_next;
    logic               power_reg,  power_next;
    logic [SPEED_W-1:0] speed_reg,  speed_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    logic               m_valid_reg, m_valid_next;
    res_t               res_reg,    res_next;

    logic               step;
    logic [COUNT_W-1:0] hold_load;
    logic [COUNT_W-1:0] deb_load;
    logic               lvl;

    assign take = !m_valid_reg || m_tready;
    assign step = item_valid && take;

    // a zero count acts as one
    assign hold_load = (cfg.hold_ticks == '0) ? COUNT_W'(1) : cfg.hold_ticks;
    assign deb_load  = (cfg.debounce_ticks == '0) ? COUNT_W'(1)
                                                  : COUNT_W'(cfg.debounce_ticks);

    always_comb
    begin
        phase_next = phase_reg;
        power_next = power_reg;
        speed_next = speed_reg;
        count_next = count_reg;
        lvl        = 1'b0;

        case (phase_reg)
            PH_CNT_POWER, PH_CNT_UP, PH_CNT_DOWN:
            begin
                if (count_reg > COUNT_W'(1))
                    count_next = count_reg - COUNT_W'(1);
                else
                begin
                    count_next = '0;
                    case (phase_reg)
                        PH_CNT_POWER: lvl = item.power;
                        PH_CNT_UP:    lvl = item.up;
                        default:      lvl = item.down;
                    endcase
                    if (!lvl)
                        phase_next = PH_IDLE;
                    else
                    begin
                        case (phase_reg)
                            PH_CNT_POWER:
                            begin
                                phase_next = PH_REL_POWER;
                                power_next = !power_reg;
                                speed_next = power_reg ? SPEED_OFF : SPEED_LOW;
                            end
                            PH_CNT_UP:
                            begin
                                phase_next = PH_REL_UP;
                                if (power_reg && speed_reg != SPEED_HIGH)
                                    speed_next = speed_reg + SPEED_W'(1);
                            end
                            default:
                            begin
                                phase_next = PH_REL_DOWN;
                                if (power_reg && speed_reg > SPEED_LOW)
                                    speed_next = speed_reg - SPEED_W'(1);
                            end
                        endcase
                    end
                end
            end
            PH_REL_POWER:
                if (!item.power) phase_next = PH_IDLE;
            PH_REL_UP:
                if (!item.up) phase_next = PH_IDLE;
            PH_REL_DOWN:
                if (!item.down) phase_next = PH_IDLE;
            default:
            begin
                // idle, and any stray code behaves as idle
                phase_next = PH_IDLE;
                if (item.power)
                begin
                    phase_next = PH_CNT_POWER;
                    count_next = hold_load;
                end
                else if (power_reg && item.up)
                begin
                    phase_next = PH_CNT_UP;
                    count_next = deb_load;
                end
                else if (power_reg && item.down)
                begin
                    phase_next = PH_CNT_DOWN;
                    count_next = deb_load;
                end
            end
        endcase

        res_next.relay_low   = (speed_next == SPEED_LOW);
        res_next.relay_mid   = (speed_next == SPEED_MID);
        res_next.relay_high  = (speed_next == SPEED_HIGH);
        res_next.fan_on      = power_next;
        res_next.speed_level = speed_next;

        m_valid_next = m_valid_reg;
        if (step)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            power_reg   <= 1'b0;
            speed_reg   <= SPEED_OFF;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            if (step)
            begin
                phase_reg <= phase_next;
                power_reg <= power_next;
                speed_reg <= speed_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign res      = res_reg;

endmodule

### rtl/core/fan_speed_button_controller.sv
// ---------------------------------------------------------------------------
// fan_speed_button_controller
// three-button fan control: power hold toggle, up/down speed with debounce
// ---------------------------------------------------------------------------
//   channel   direction  carries
//   s_*       in         one tick item: power, up, down button levels
//   m_*       out        one result item per tick: relays, fan_on, speed_level
//   cfg_*     in         register writes: hold_ticks (0), debounce_ticks (1)
//
// one item per cycle sustained while m_tready is high; an accepted item goes
// through the input register, then the sequencer step into the result register
// the sequencer state updates only when an item moves into the result register
// a stalled result holds the input register, so s_tready falls once both are full
// reset: fan off, speed zero, idle, hold_ticks 2000, debounce_ticks 5
// ---------------------------------------------------------------------------
`include "fan_speed_button_controller_assert.svh"

module fan_speed_button_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    // item input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // bit 0 power_pressed, bit 1 up_pressed, bit 2 down_pressed, 7:3 zero
    input  logic [fsbc_pkg::IN_DATA_W-1:0]   s_tdata,
    // result output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // bit 0 relay_low, 1 relay_mid, 2 relay_high, 3 fan_on, 5:4 speed_level, 7:6 zero
    output logic [fsbc_pkg::OUT_DATA_W-1:0]  m_tdata,
    // register writes
    input  logic                             cfg_we,
    input  logic [fsbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fsbc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import fsbc_pkg::*;

    cfg_t cfg;
    btn_t item;
    logic item_valid;
    logic take;
    res_t res;

    // hold and debounce registers
    fsbc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // input register, frees itself when the sequencer takes the item
    fsbc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // press counting, actions and the result register
    fsbc_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .res        (res)
    );

    assign m_tdata = {{(OUT_DATA_W - $bits(res_t)){1'b0}}, res};

    // fan is on exactly when some speed is selected
    `FSBC_ASSERT_SAME(a_on_speed, clk, rst_n, m_tvalid, res.fan_on == (res.speed_level != SPEED_OFF), "fan_on disagrees with speed")
    // relays follow the speed level, at most one closed
    `FSBC_ASSERT_SAME(a_relays, clk, rst_n, m_tvalid, $onehot0({res.relay_high, res.relay_mid, res.relay_low}) && (res.relay_mid == (res.speed_level == SPEED_MID)), "relay drive disagrees with speed")
    // a held item is not dropped while the result side stalls
    `FSBC_ASSERT_NEXT(a_hold_item, clk, rst_n, item_valid && !take, item_valid && $stable(item), "input item lost under stall")

endmodule

### sim/fsbc_relay_checker.sv
// ---------------------------------------------------------------------------
// fsbc_relay_checker
// watches the tick and result channels and the register port, tracks the
// expected relay and speed state per tick and compares every result item
// ---------------------------------------------------------------------------
module fsbc_relay_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [fsbc_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [fsbc_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_we,
    input  logic [fsbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              outstanding,
    output int                              fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import fsbc_pkg::*;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_COUNT_POWER,
        SEQ_COUNT_UP,
        SEQ_COUNT_DOWN,
        SEQ_WAIT_POWER,
        SEQ_WAIT_UP,
        SEQ_WAIT_DOWN
    } seq_t;

    logic [HOLD_W-1:0]  hold_reg = HOLD_RESET;
    logic [DEB_W-1:0]   deb_reg = DEB_RESET;
    logic               fan = 1'b0;
    logic [SPEED_W-1:0] speed = SPEED_OFF;
    seq_t               seq = SEQ_IDLE;
    logic [COUNT_W-1:0] countdown = '0;
    res_t               expected_relays_q[$];
    int                 mismatches = 0;

    // a register value of zero counts as one tick
    function automatic logic [COUNT_W-1:0] load_value(input logic [COUNT_W-1:0] v);
        return (v == '0) ? COUNT_W'(1) : v;
    endfunction

    function automatic void apply_action(input seq_t which);
        if (which == SEQ_COUNT_POWER) begin
            fan   = ~fan;
            speed = fan ? SPEED_LOW : SPEED_OFF;
        end
        else if (which == SEQ_COUNT_UP) begin
            if (fan && speed < SPEED_HIGH)
                speed = speed + 1'b1;
        end
        else if (fan && speed > SPEED_LOW) begin
            speed = speed - 1'b1;
        end
    endfunction

    // one tick of the button sequencer, returns the result item it causes
    function automatic res_t advance_tick(input btn_t b);
        res_t r;
        logic lvl;
        case (seq)
            SEQ_COUNT_POWER, SEQ_COUNT_UP, SEQ_COUNT_DOWN:
            begin
                if (countdown > 1) begin
                    countdown = countdown - 1'b1;
                end
                else begin
                    case (seq)
                        SEQ_COUNT_POWER: lvl = b.power;
                        SEQ_COUNT_UP:    lvl = b.up;
                        default:         lvl = b.down;
                    endcase
                    countdown = '0;
                    if (lvl) begin
                        apply_action(seq);
                        case (seq)
                            SEQ_COUNT_POWER: seq = SEQ_WAIT_POWER;
                            SEQ_COUNT_UP:    seq = SEQ_WAIT_UP;
                            default:         seq = SEQ_WAIT_DOWN;
                        endcase
                    end
                    else begin
                        seq = SEQ_IDLE;
                    end
                end
            end
            SEQ_WAIT_POWER: if (!b.power) seq = SEQ_IDLE;
            SEQ_WAIT_UP:    if (!b.up) seq = SEQ_IDLE;
            SEQ_WAIT_DOWN:  if (!b.down) seq = SEQ_IDLE;
            default:
            begin
                seq = SEQ_IDLE;
                if (b.power) begin
                    seq       = SEQ_COUNT_POWER;
                    countdown = load_value(COUNT_W'(hold_reg));
                end
                else if (fan && b.up) begin
                    seq       = SEQ_COUNT_UP;
                    countdown = load_value(COUNT_W'(deb_reg));
                end
                else if (fan && b.down) begin
                    seq       = SEQ_COUNT_DOWN;
                    countdown = load_value(COUNT_W'(deb_reg));
                end
            end
        endcase
        r.relay_low   = (speed == SPEED_LOW);
        r.relay_mid   = (speed == SPEED_MID);
        r.relay_high  = (speed == SPEED_HIGH);
        r.fan_on      = fan;
        r.speed_level = speed;
        return r;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin : track
        res_t want;
        res_t got;
        if (!rst_n) begin
            hold_reg  = HOLD_RESET;
            deb_reg   = DEB_RESET;
            fan       = 1'b0;
            speed     = SPEED_OFF;
            seq       = SEQ_IDLE;
            countdown = '0;
            expected_relays_q.delete();
            outstanding <= 0;
            fail_count  <= mismatches;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_HOLD_TICKS)
                    hold_reg = cfg_wdata[HOLD_W-1:0];
                else if (cfg_index == CFG_DEBOUNCE_TICKS)
                    deb_reg = cfg_wdata[DEB_W-1:0];
            end
            if (s_tvalid && s_tready)
                expected_relays_q.push_back(advance_tick(btn_t'(s_tdata[2:0])));
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[5:0]);
                if (expected_relays_q.size() == 0) begin
                    $error("result item 0x%h with no tick waiting", m_tdata);
                    mismatches++;
                end
                else begin
                    want = expected_relays_q.pop_front();
                    compare_field("relay_low", want.relay_low, got.relay_low);
                    compare_field("relay_mid", want.relay_mid, got.relay_mid);
                    compare_field("relay_high", want.relay_high, got.relay_high);
                    compare_field("fan_on", want.fan_on, got.fan_on);
                    compare_field("speed_level", want.speed_level, got.speed_level);
                end
            end
            outstanding <= expected_relays_q.size();
            fail_count  <= mismatches;
        end
    end

endmodule

### sim/fan_speed_button_controller_tb.sv
// ---------------------------------------------------------------------------
// fan_speed_button_controller_tb
// drives button tick items through the fan controller under several register
// settings and handshake pacing modes; the relay checker predicts each result
// ---------------------------------------------------------------------------
module fan_speed_button_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsbc_pkg::*;

    // how the two sides of the stream idle
    typedef enum logic [1:0] {
        PACE_STEADY,
        PACE_SENDER_GAPS,
        PACE_RECEIVER_STALLS,
        PACE_BOTH
    } pace_t;

    // which button a press gesture is built around
    typedef enum logic [1:0] {
        KEY_POWER,
        KEY_UP,
        KEY_DOWN,
        KEY_NOISE
    } key_t;

    localparam int GAP_PCT       = 46;
    localparam int BOTH_PCT      = 38;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int PHASE_TICKS   = 250;

    // hand-picked opening: buttons while off, all three at once (power wins),
    // down saturating at low, up beating down, the release tick ignoring a
    // held down, up saturating at high, then power off
    localparam logic [2:0] OPENING_TICKS [25] = '{
        3'b010, 3'b100, 3'b000,
        3'b111, 3'b111, 3'b111, 3'b011, 3'b000,
        3'b100, 3'b100, 3'b000,
        3'b110, 3'b110, 3'b100, 3'b000,
        3'b010, 3'b010, 3'b000, 3'b010, 3'b010, 3'b000,
        3'b001, 3'b001, 3'b001, 3'b000
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int    outstanding;
    int    fail_count;
    pace_t pace = PACE_STEADY;
    int    hold_now = HOLD_RESET;    // register values as last written
    int    deb_now = DEB_RESET;
    int    ticks_sent = 0;
    int    stall_seq = 0;            // bumped to ask the receiver for a long hold-off

    fan_speed_button_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fsbc_relay_checker relay_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // generous ceiling: the slowest correct run is well under a tenth of this
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stalls per pacing mode, plus a long hold-off on request
    // so the block's two stages fill and s_tready drops
    always @(posedge clk) begin : receiver
        static int hold_left = 0;
        static int seen_seq = 0;
        if (seen_seq != stall_seq) begin
            seen_seq  = stall_seq;
            hold_left = HOLD_OFF_LEN;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (pace == PACE_RECEIVER_STALLS)
            m_tready <= ($urandom_range(99) >= GAP_PCT);
        else if (pace == PACE_BOTH)
            m_tready <= ($urandom_range(99) >= BOTH_PCT);
        else
            m_tready <= 1'b1;
    end

    function automatic int effective(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    // offer one tick item, with random idle cycles ahead of it, and wait
    // for the handshake; tvalid stays high on return
    task automatic send_item(input btn_t b);
        int gap_pct;
        gap_pct = (pace == PACE_SENDER_GAPS) ? GAP_PCT :
                  (pace == PACE_BOTH)        ? BOTH_PCT : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-3){1'b0}}, b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ticks_sent++;
    endtask

    // stop offering and wait until every tick has its result back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // both registers back to back; debounce data gets random upper bits,
    // which the block must drop
    task automatic set_config(input int hold, input int deb);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HOLD_TICKS;
        cfg_wdata <= CFG_DATA_W'(hold);
        @(posedge clk);
        cfg_index <= CFG_DEBOUNCE_TICKS;
        cfg_wdata <= {8'($urandom_range(255)), 8'(deb)};
        @(posedge clk);
        cfg_we   <= 1'b0;
        hold_now = hold;
        deb_now  = deb;
    endtask

    // key held for len ticks, then rel ticks with the key released; other
    // buttons chatter now and then, a noise gesture is random throughout
    task automatic gesture(input key_t key, input int len, input int rel);
        btn_t b;
        for (int i = 0; i < len + rel; i++) begin
            b = (key == KEY_NOISE || $urandom_range(3) == 0) ?
                btn_t'($urandom_range(7)) : btn_t'(3'b000);
            case (key)
                KEY_POWER: b.power = (i < len);
                KEY_UP:    b.up    = (i < len);
                KEY_DOWN:  b.down  = (i < len);
                default:   ;
            endcase
            send_item(b);
        end
    endtask

    // mostly well-formed presses whose length sits around the confirm count:
    // one short (dropped at the sample), exactly enough, longer, or anything
    task automatic random_gesture();
        key_t key;
        int   n;
        int   len;
        int   pick;
        pick = $urandom_range(99);
        key  = (pick < 25) ? KEY_POWER : (pick < 55) ? KEY_UP :
               (pick < 80) ? KEY_DOWN : KEY_NOISE;
        if (key == KEY_NOISE) begin
            gesture(key, $urandom_range(6, 1), 0);
        end
        else begin
            n = (key == KEY_POWER) ? effective(hold_now) : effective(deb_now);
            case ($urandom_range(3))
                0:       len = n;
                1:       len = n + 1;
                2:       len = n + 1 + $urandom_range(4);
                default: len = $urandom_range(n + 2, 1);
            endcase
            gesture(key, len, $urandom_range(3, 1));
        end
    endtask

    // one random phase under a register setting and pacing mode; squeeze
    // asks for the long receiver hold-off partway in
    task automatic run_phase(input int hold, input int deb, input pace_t p, input bit squeeze);
        int start;
        bit squeezed;
        settle();
        set_config(hold, deb);
        pace <= p;
        start    = ticks_sent;
        squeezed = 1'b0;
        while (ticks_sent - start < PHASE_TICKS) begin
            if (squeeze && !squeezed && ticks_sent - start >= 100) begin
                stall_seq <= stall_seq + 1;
                squeezed = 1'b1;
            end
            random_gesture();
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // short hold so the fan comes on quickly, debounce kept at its reset
        // value of 5: up missed by one tick and met, then a power hold
        // released right at its sample
        pace <= PACE_SENDER_GAPS;
        set_config(2, DEB_RESET);
        gesture(KEY_POWER, 3, 2);
        gesture(KEY_UP, 5, 1);
        gesture(KEY_UP, 6, 1);
        gesture(KEY_POWER, 2, 1);

        // opening sequence with debounce written as zero (counts as one)
        settle();
        set_config(2, 0);
        pace <= PACE_STEADY;
        for (int i = 0; i < 25; i++)
            send_item(btn_t'(OPENING_TICKS[i]));

        // random phases across register settings and pacing
        run_phase(1, 1, PACE_STEADY, 1'b0);
        run_phase(3, 2, PACE_SENDER_GAPS, 1'b0);
        run_phase(5, 4, PACE_RECEIVER_STALLS, 1'b1);
        run_phase(2, 1, PACE_BOTH, 1'b0);
        run_phase(0, 255, PACE_STEADY, 1'b0);
        run_phase(4, 3, PACE_BOTH, 1'b1);
        run_phase(9, 0, PACE_RECEIVER_STALLS, 1'b0);
        run_phase(6, 7, PACE_SENDER_GAPS, 1'b0);

        // drain, then give the two-stage pipe time to show any stray result
        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
